FILE: design/c_source_comment_whitespace_stripper_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the C source comment and whitespace stripper
// Short forms of the concurrent checks used at the top level. They expect
// signals named clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef C_SOURCE_COMMENT_WHITESPACE_STRIPPER_UNIT_MACROS_SVH
`define C_SOURCE_COMMENT_WHITESPACE_STRIPPER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CSCWS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSCWS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/cscws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscws_pkg
// Shared types, character codes and separator classification for the
// C source comment and whitespace stripper.
// ----------------------------------------------------------------------------
package cscws_pkg;

	localparam int MAX_NEST = 15;
	localparam int DEPTH_W  = $clog2(MAX_NEST + 1);
	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	typedef enum logic [2:0] {
		M_NORMAL    = 3'd0,
		M_SLASH     = 3'd1,
		M_CMT       = 3'd2,
		M_CMT_SLASH = 3'd3,
		M_CMT_STAR  = 3'd4,
		M_QUOTE     = 3'd5,
		M_QUOTE_ESC = 3'd6
	} mode_t;

	// One classified input beat.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       ws;
		logic       sep;
	} tok_t;

	// One result beat.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       has_byte;
		logic       end_of_output;
	} res_t;

	function automatic logic is_ws(logic [7:0] c);
		return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
	endfunction

	function automatic logic is_sep(logic [7:0] c);
		logic p;
		p = 1'b0;
		unique case (c)
			8'h2C, 8'h3B, 8'h3D, 8'h2B, 8'h2D, 8'h21, 8'h3F, 8'h3A, 8'h2A,
			8'h25, 8'h26, 8'h7C, 8'h2F, 8'h3C, 8'h3E, 8'h28, 8'h29, 8'h5B,
			8'h5D, 8'h7B, 8'h7D: p = 1'b1;
			default: p = 1'b0;
		endcase
		return p || is_ws(c);
	endfunction

endpackage

FILE: design/cscws_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscws stream interfaces
// Valid/ready channels for source bytes in and stripped bytes out.
// ----------------------------------------------------------------------------
interface cscws_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source (output valid, output in_byte, output last_byte, input ready);
	modport sink (input valid, input in_byte, input last_byte, output ready);
endinterface

interface cscws_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       has_byte;
	logic       end_of_output;

	modport source (output valid, output out_byte, output has_byte,
		output end_of_output, input ready);
	modport sink (input valid, input out_byte, input has_byte,
		input end_of_output, output ready);
endinterface

FILE: design/cscws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscws_front
// Accepts source bytes, classifies them as whitespace or separators and
// registers the classified beat toward the queue.
// ----------------------------------------------------------------------------
module cscws_front (
	input  logic              clk,
	input  logic              arst_n,
	cscws_in_if.sink          din,
	output logic              tok_valid,
	input  logic              tok_ready,
	output cscws_pkg::tok_t   tok
);
	import cscws_pkg::*;

	logic vld_s1;
	tok_t tok_s1;
	logic take;

	assign din.ready = !vld_s1 || tok_ready;
	assign take      = din.valid && din.ready;
	assign tok_valid = vld_s1;
	assign tok       = tok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (din.ready) begin
			vld_s1 <= din.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_s1.data <= din.in_byte;
			tok_s1.last <= din.last_byte;
			tok_s1.ws   <= is_ws(din.in_byte);
			tok_s1.sep  <= is_sep(din.in_byte);
		end
	end

endmodule

FILE: design/cscws_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscws_fifo
// Short queue of classified beats between the front and the back.
// ----------------------------------------------------------------------------
module cscws_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  cscws_pkg::tok_t   wr_tok,
	output logic              rd_valid,
	input  logic              rd_ready,
	output cscws_pkg::tok_t   rd_tok
);
	import cscws_pkg::*;

	tok_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign wr_ready = cnt_q != QCNT_W'(QDEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_tok   = mem_q[rptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_tok;
		end
	end

endmodule

FILE: design/cscws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscws_back
// Scanner state machine: comment nesting, quotes, directives and held
// blanks or slashes. Each beat yields up to two results, kept in a
// two-entry result register that drives the output channel.
// ----------------------------------------------------------------------------
module cscws_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tok_valid,
	output logic              tok_ready,
	input  cscws_pkg::tok_t   tok,
	cscws_out_if.source       dout
);
	import cscws_pkg::*;

	typedef struct packed {
		logic [1:0] n;
		logic [7:0] o0;
		logic [7:0] o1;
		logic [7:0] lo;
		logic       an;
	} acc_t;

	function automatic acc_t emit_f(acc_t a, logic [7:0] x);
		acc_t r;
		r = a;
		if (a.n == 2'd0) begin
			r.o0 = x;
		end else if (a.n == 2'd1) begin
			r.o1 = x;
		end
		if (a.n != 2'd2) begin
			r.n = a.n + 2'd1;
		end
		r.lo = x;
		r.an = 1'b1;
		return r;
	endfunction

	mode_t              mode_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               dir_q;
	logic [7:0]         last_out_q;
	logic               any_q;
	logic               blank_q;
	logic               tab_q;
	logic [1:0]         rcnt_q;
	res_t               r0_q;
	res_t               r1_q;

	mode_t              nm;
	logic [DEPTH_W-1:0] nd;
	logic               ndir;
	logic               nbh;
	logic               nht;
	logic               do_normal;
	logic               keep;
	acc_t               acc;
	logic [7:0]         c;
	logic [1:0]         rn;
	res_t               res0;
	res_t               res1;
	logic               take;
	logic               out_fire;

	assign c = tok.data;

	always_comb begin
		nm        = mode_q;
		nd        = depth_q;
		ndir      = dir_q;
		nbh       = blank_q;
		nht       = tab_q;
		do_normal = 1'b0;
		keep      = 1'b0;
		acc       = '{n: 2'd0, o0: 8'h00, o1: 8'h00, lo: last_out_q, an: any_q};

		unique case (mode_q)
			M_SLASH: begin
				if (c == CH_STAR) begin
					nm = M_CMT;
					nd = DEPTH_W'(1);
				end else begin
					acc       = emit_f(acc, CH_SLASH);
					nm        = M_NORMAL;
					do_normal = 1'b1;
				end
			end
			M_CMT, M_CMT_SLASH, M_CMT_STAR: begin
				if (mode_q == M_CMT_SLASH && c == CH_STAR) begin
					if (nd < DEPTH_W'(MAX_NEST)) begin
						nd = nd + 1'b1;
					end
					nm = M_CMT;
				end else if (mode_q == M_CMT_STAR && c == CH_SLASH) begin
					if (nd != '0) begin
						nd = nd - 1'b1;
					end
					nm = (nd == '0) ? M_NORMAL : M_CMT;
				end else if (c == CH_SLASH) begin
					nm = M_CMT_SLASH;
				end else if (c == CH_STAR) begin
					nm = M_CMT_STAR;
				end else begin
					nm = M_CMT;
				end
			end
			M_QUOTE: begin
				acc = emit_f(acc, c);
				if (c == CH_BSL) begin
					nm = M_QUOTE_ESC;
				end else if (c == (tab_q ? CH_SQ : CH_DQ)) begin
					nm  = M_NORMAL;
					nht = 1'b0;
				end
			end
			M_QUOTE_ESC: begin
				acc = emit_f(acc, c);
				nm  = M_QUOTE;
			end
			default: begin
				nm = M_NORMAL;
				if (blank_q) begin
					if (dir_q) begin
						keep = acc.an && !tok.ws && !is_ws(acc.lo);
					end else begin
						keep = acc.an && !tok.sep && !is_sep(acc.lo);
					end
					if (keep) begin
						acc = emit_f(acc, tab_q ? CH_TAB : CH_SP);
					end
					nbh = 1'b0;
					nht = 1'b0;
				end
				do_normal = 1'b1;
			end
		endcase

		if (do_normal) begin
			unique case (c)
				CH_SP, CH_TAB: begin
					nbh = 1'b1;
					nht = (c == CH_TAB);
				end
				CH_HASH: begin
					acc  = emit_f(acc, c);
					ndir = 1'b1;
				end
				CH_CR: begin
					// A directive ends at a CR unless a backslash continues the line.
					if (ndir && acc.an && acc.lo != CH_BSL) begin
						ndir = 1'b0;
					end
					if (acc.an && acc.lo != CH_LF) begin
						acc = emit_f(acc, c);
					end
				end
				CH_LF: begin
					if (acc.an && acc.lo != CH_LF) begin
						acc = emit_f(acc, c);
					end
				end
				CH_SLASH: begin
					nm = M_SLASH;
				end
				CH_DQ, CH_SQ: begin
					acc = emit_f(acc, c);
					nm  = M_QUOTE;
					nht = (c == CH_SQ);
				end
				default: begin
					acc = emit_f(acc, c);
				end
			endcase
		end

		// A slash still held at end of file is kept.
		if (tok.last && nm == M_SLASH) begin
			acc = emit_f(acc, CH_SLASH);
		end

		rn   = acc.n;
		res0 = '{out_byte: acc.o0, has_byte: 1'b1, end_of_output: 1'b0};
		res1 = '{out_byte: acc.o1, has_byte: 1'b1, end_of_output: 1'b0};
		if (tok.last) begin
			if (acc.n == 2'd0) begin
				rn   = 2'd1;
				res0 = '{out_byte: 8'h00, has_byte: 1'b0, end_of_output: 1'b1};
			end else if (acc.n == 2'd1) begin
				res0.end_of_output = 1'b1;
			end else begin
				res1.end_of_output = 1'b1;
			end
		end
	end

	assign out_fire  = (rcnt_q != 2'd0) && dout.ready;
	assign tok_ready = (rcnt_q == 2'd0) || ((rcnt_q == 2'd1) && dout.ready);
	assign take      = tok_valid && tok_ready;

	assign dout.valid         = rcnt_q != 2'd0;
	assign dout.out_byte      = r0_q.out_byte;
	assign dout.has_byte      = r0_q.has_byte;
	assign dout.end_of_output = r0_q.end_of_output;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= M_NORMAL;
			depth_q    <= '0;
			dir_q      <= 1'b0;
			last_out_q <= 8'h00;
			any_q      <= 1'b0;
			blank_q    <= 1'b0;
			tab_q      <= 1'b0;
			rcnt_q     <= 2'd0;
		end else begin
			if (take) begin
				rcnt_q <= rn;
				if (tok.last) begin
					// The file is done: the next beat starts a fresh one.
					mode_q     <= M_NORMAL;
					depth_q    <= '0;
					dir_q      <= 1'b0;
					last_out_q <= 8'h00;
					any_q      <= 1'b0;
					blank_q    <= 1'b0;
					tab_q      <= 1'b0;
				end else begin
					mode_q     <= nm;
					depth_q    <= nd;
					dir_q      <= ndir;
					last_out_q <= acc.lo;
					any_q      <= acc.an;
					blank_q    <= nbh;
					tab_q      <= nht;
				end
			end else if (out_fire) begin
				rcnt_q <= rcnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			r0_q <= res0;
			r1_q <= res1;
		end else if (out_fire) begin
			r0_q <= r1_q;
		end
	end

endmodule

FILE: design/c_source_comment_whitespace_stripper_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// C source comment and whitespace stripper
// Streams C source bytes in and shortened source bytes out, removing nested
// block comments and redundant blanks and blank lines.
// ----------------------------------------------------------------------------
// Usage: one source byte is accepted per beat on din, with last_byte marking
// the end of a file; results leave on dout one per beat, and the last result
// of a file carries end_of_output (an empty end marker has has_byte low).
// A byte that is accepted passes the classification register, a four-entry
// queue and the result register on its way to the output. The block sustains
// one source byte per cycle while each byte yields at most one result and dout
// is ready; a byte that yields two results holds the result register until
// both have left, since dout moves one result per cycle. Configuration is
// fixed; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "c_source_comment_whitespace_stripper_unit_macros.svh"

module c_source_comment_whitespace_stripper_unit (
	input  logic       clk,
	input  logic       arst_n,
	cscws_in_if.sink   din,
	cscws_out_if.source dout
);
	import cscws_pkg::*;

	logic f_valid;
	logic f_ready;
	tok_t f_tok;
	logic q_valid;
	logic q_ready;
	tok_t q_tok;

	cscws_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	cscws_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_tok   (f_tok),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_tok   (q_tok)
	);

	cscws_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (q_valid),
		.tok_ready (q_ready),
		.tok       (q_tok),
		.dout      (dout)
	);

	// An accepted beat always lands in the classification register.
	`CSCWS_ASSERT_NEXT(a_front_load, din.valid && din.ready, f_valid, "accepted beat lost in front")
	// The back must not take a new beat while a stalled result is pending.
	`CSCWS_ASSERT_NOW(a_back_hold, dout.valid && !dout.ready, !(q_valid && q_ready), "back popped while output stalled")
	// A result without a byte can only be the end marker of a file.
	`CSCWS_ASSERT_NOW(a_empty_is_end, dout.valid && !dout.has_byte, dout.end_of_output, "empty result without end mark")

endmodule
